// ----- rtl/ps2_mouse_packet_decoder_core_assert.svh -----
// ---------------------------------------------------------------------------
// ps2 mouse packet decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_CORE_ASSERT_SVH

// checked only while out of reset
`define PS2MD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PS2MD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ps2md_pkg.sv -----
// ---------------------------------------------------------------------------
// ps2md_pkg
// types, constants and helpers shared by the ps2 mouse packet decoder
// ---------------------------------------------------------------------------
`default_nettype none

package ps2md_pkg;

  localparam int unsigned ExtW       = 12;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [7:0]  AckByte    = 8'hFA;
  localparam logic [7:0]  SyncMask   = 8'hC8;
  localparam logic [7:0]  SyncValue  = 8'h08;

  localparam logic [ExtW-1:0] CursorSize   = 12'd16;
  localparam logic [ExtW-1:0] CentreMarginY = 12'd44; // menu bar plus cursor

  localparam logic [ExtW-1:0] ResetWidth  = 12'd320;
  localparam logic [ExtW-1:0] ResetHeight = 12'd200;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 1'b1;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef enum logic [1:0] {
    PhAck    = 2'd0,
    PhHeader = 2'd1,
    PhX      = 2'd2,
    PhY      = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [ExtW-1:0] centre(input logic [ExtW-1:0] ext,
                                             input logic [ExtW-1:0] margin);
    logic [ExtW-1:0] diff;
    diff = ext - margin;
    if (ext < margin) begin
      return '0;
    end
    return {1'b0, diff[ExtW-1:1]};
  endfunction

  function automatic logic [ExtW-1:0] upper_bound(input logic [ExtW-1:0] ext);
    if (ext < CursorSize) begin
      return '0;
    end
    return ext - CursorSize;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ps2md_front.sv -----
// ---------------------------------------------------------------------------
// ps2md_front
// byte intake: acknowledge wait, header sync and packet assembly
// ---------------------------------------------------------------------------
`default_nettype none

module ps2md_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            mouse_byte_i,
  input  wire ps2md_pkg::q_status_t  q_status_i,
  output logic                       push_o,
  output ps2md_pkg::pkt_t            pkt_o
);

  ps2md_pkg::phase_e phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xb_q, xb_d;
  logic       accept;
  logic       sync_ok;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign sync_ok    = (mouse_byte_i & ps2md_pkg::SyncMask) == ps2md_pkg::SyncValue;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        ps2md_pkg::PhAck: begin
          if (mouse_byte_i == ps2md_pkg::AckByte) begin
            phase_d = ps2md_pkg::PhHeader;
          end
        end
        ps2md_pkg::PhHeader: begin
          if (sync_ok) begin
            phase_d = ps2md_pkg::PhX;
          end
        end
        ps2md_pkg::PhX: begin
          phase_d = ps2md_pkg::PhY;
        end
        ps2md_pkg::PhY: begin
          phase_d = ps2md_pkg::PhHeader;
        end
        default: begin
          phase_d = ps2md_pkg::PhAck;
        end
      endcase
    end
  end

  always_comb begin
    hdr_d  = hdr_q;
    xb_d   = xb_q;
    push_o = 1'b0;
    case (phase_q)
      ps2md_pkg::PhHeader: begin
        if (accept && sync_ok) begin
          hdr_d = mouse_byte_i;
        end
      end
      ps2md_pkg::PhX: begin
        if (accept) begin
          xb_d = mouse_byte_i;
        end
      end
      ps2md_pkg::PhY: begin
        push_o = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // y sign extended to ten bits, then negated so that down is positive
  assign pkt_o.buttons = hdr_q[2:0];
  assign pkt_o.delta_x = {hdr_q[4], xb_q};
  assign pkt_o.delta_y = 10'd0 - {hdr_q[5], hdr_q[5], mouse_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ps2md_pkg::PhAck;
      hdr_q   <= '0;
      xb_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      xb_q    <= xb_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ps2md_queue.sv -----
// ---------------------------------------------------------------------------
// ps2md_queue
// short packet queue between the byte intake and the cursor update
// ---------------------------------------------------------------------------
`default_nettype none

module ps2md_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ps2md_pkg::pkt_t       pkt_i,
  input  wire logic                  pop_i,
  output ps2md_pkg::pkt_t            pkt_o,
  output ps2md_pkg::q_status_t       status_o
);

  localparam logic [ps2md_pkg::QueuePtrW-1:0] LastPtr =
    ps2md_pkg::QueuePtrW'(ps2md_pkg::QueueDepth - 1);
  localparam logic [ps2md_pkg::QueueCntW-1:0] FullCnt =
    ps2md_pkg::QueueCntW'(ps2md_pkg::QueueDepth);

  ps2md_pkg::pkt_t entries_q [ps2md_pkg::QueueDepth];
  logic [ps2md_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ps2md_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ps2md_pkg::QueueCntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = cnt_q == FullCnt;
  assign status_o.empty = cnt_q == '0;
  assign pkt_o          = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ps2md_back.sv -----
// ---------------------------------------------------------------------------
// ps2md_back
// screen size registers, cursor update with clamping and output register
// ---------------------------------------------------------------------------
`default_nettype none

module ps2md_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ps2md_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ps2md_pkg::ExtW-1:0]    cfg_data_i,
  input  wire ps2md_pkg::q_status_t          q_status_i,
  input  wire ps2md_pkg::pkt_t               pkt_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         buttons_o,
  output logic signed [8:0]                  delta_x_o,
  output logic signed [9:0]                  delta_y_o,
  output logic [ps2md_pkg::ExtW-1:0]         cursor_x_o,
  output logic [ps2md_pkg::ExtW-1:0]         cursor_y_o
);

  localparam int unsigned SumW = ps2md_pkg::ExtW + 2;

  logic [ps2md_pkg::ExtW-1:0] width_q, width_d;
  logic [ps2md_pkg::ExtW-1:0] height_q, height_d;
  logic [ps2md_pkg::ExtW-1:0] ptr_x_q, ptr_x_d;
  logic [ps2md_pkg::ExtW-1:0] ptr_y_q, ptr_y_d;
  logic                       out_valid_q, out_valid_d;
  logic [2:0]                 buttons_q;
  logic signed [8:0]          delta_x_q;
  logic signed [9:0]          delta_y_q;
  logic [ps2md_pkg::ExtW-1:0] hi_x, hi_y;
  logic [ps2md_pkg::ExtW-1:0] new_x, new_y;
  logic [SumW-1:0]            sum_x, sum_y;

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  assign hi_x = ps2md_pkg::upper_bound(width_q);
  assign hi_y = ps2md_pkg::upper_bound(height_q);

  assign sum_x = {2'b00, ptr_x_q} + {{(SumW-9){pkt_i.delta_x[8]}}, pkt_i.delta_x};
  assign sum_y = {2'b00, ptr_y_q} + {{(SumW-10){pkt_i.delta_y[9]}}, pkt_i.delta_y};

  // negative sum pins to zero, anything past the edge pins to the bound
  always_comb begin
    if (sum_x[SumW-1]) begin
      new_x = '0;
    end else if (sum_x[SumW-2:0] > {1'b0, hi_x}) begin
      new_x = hi_x;
    end else begin
      new_x = sum_x[ps2md_pkg::ExtW-1:0];
    end
    if (sum_y[SumW-1]) begin
      new_y = '0;
    end else if (sum_y[SumW-2:0] > {1'b0, hi_y}) begin
      new_y = hi_y;
    end else begin
      new_y = sum_y[ps2md_pkg::ExtW-1:0];
    end
  end

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    ptr_x_d     = ptr_x_q;
    ptr_y_d     = ptr_y_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2md_pkg::RegScreenWidth:  width_d  = cfg_data_i;
        ps2md_pkg::RegScreenHeight: height_d = cfg_data_i;
        default:                    width_d  = width_q;
      endcase
      // any size write recentres the cursor
      ptr_x_d = ps2md_pkg::centre(width_d, ps2md_pkg::CursorSize);
      ptr_y_d = ps2md_pkg::centre(height_d, ps2md_pkg::CentreMarginY);
    end else if (pop_o) begin
      ptr_x_d = new_x;
      ptr_y_d = new_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ps2md_pkg::ResetWidth;
      height_q    <= ps2md_pkg::ResetHeight;
      ptr_x_q     <= ps2md_pkg::centre(ps2md_pkg::ResetWidth, ps2md_pkg::CursorSize);
      ptr_y_q     <= ps2md_pkg::centre(ps2md_pkg::ResetHeight, ps2md_pkg::CentreMarginY);
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      ptr_x_q     <= ptr_x_d;
      ptr_y_q     <= ptr_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      buttons_q <= pkt_i.buttons;
      delta_x_q <= pkt_i.delta_x;
      delta_y_q <= pkt_i.delta_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign buttons_o   = buttons_q;
  assign delta_x_o   = delta_x_q;
  assign delta_y_o   = delta_y_q;
  assign cursor_x_o  = ptr_x_q;
  assign cursor_y_o  = ptr_y_q;

endmodule

`default_nettype wire

// ----- rtl/ps2_mouse_packet_decoder_core.sv -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// ps2 mouse three-byte packet decoder with a clamped cursor
// ---------------------------------------------------------------------------
// input channel: one raw mouse byte per request (in_valid_i / in_stall_o).
// bytes are dropped until the 0xfa acknowledge, then headers are synced on
// bits 7,6,3 and each header, x and y byte triple gives one result request
// (out_valid_o / out_stall_i) with buttons, deltas and the clamped cursor.
// throughput: one byte per cycle; the intake and the cursor update are split
// by a two-entry packet queue, so a stalled result does not hold the intake
// until that queue is full.
// path: the y byte is written into the queue, then the cursor adder feeds the
// output register once that register is free to take a new result.
// configuration: cfg_we_i writes screen width (index 0) or height (index 1)
// and recentres the cursor; write only while no packet is in flight.
// reset: phase waits for the acknowledge, screen is 320 x 200 and the cursor
// sits at the centre; while out_stall_i is high the result holds steady.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_decoder_core_assert.svh"

module ps2_mouse_packet_decoder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ps2md_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ps2md_pkg::ExtW-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    mouse_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         buttons_o,
  output logic signed [8:0]                  delta_x_o,
  output logic signed [9:0]                  delta_y_o,
  output logic [ps2md_pkg::ExtW-1:0]         cursor_x_o,
  output logic [ps2md_pkg::ExtW-1:0]         cursor_y_o
);

  ps2md_pkg::q_status_t q_status;
  ps2md_pkg::pkt_t      push_pkt;
  ps2md_pkg::pkt_t      head_pkt;
  logic                 push;
  logic                 pop;

  ps2md_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mouse_byte_i (mouse_byte_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .pkt_o        (push_pkt)
  );

  ps2md_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pkt_i    (push_pkt),
    .pop_i    (pop),
    .pkt_o    (head_pkt),
    .status_o (q_status)
  );

  ps2md_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .pkt_i       (head_pkt),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .buttons_o   (buttons_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o)
  );

  `PS2MD_ASSERT(a_no_push_when_full, clk_i, rst_ni, push |-> !q_status.full, "queue overflow")
  `PS2MD_ASSERT(a_no_pop_when_empty, clk_i, rst_ni, pop |-> !q_status.empty, "queue underflow")
  `PS2MD_ASSERT(a_result_from_pop, clk_i, rst_ni, $rose(out_valid_o) |-> $past(pop), "result without packet")

endmodule

`default_nettype wire

// ----- tb/ps2_mouse_packet_decoder_core_test.sv -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core_test
// drives raw mouse bytes and screen settings into the decoder, predicts each
// packet report and its clamped cursor, and checks every report field by field
// ---------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2md_pkg::*;

  localparam int unsigned RunLimit      = 300000;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned PhaseBytes    = 105;
  localparam int unsigned XSignBit      = 4;
  localparam int unsigned YSignBit      = 5;
  localparam logic [ExtW-1:0] ExtentMax = 12'd4095;
  localparam logic [ExtW-1:0] WidthMin  = 12'd16;
  localparam logic [ExtW-1:0] HeightMin = 12'd44;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
    logic [ExtW-1:0]   cursor_x;
    logic [ExtW-1:0]   cursor_y;
  } mouse_report_t;

  class mouse_report_tracker;
    logic [ExtW-1:0] screen_w;
    logic [ExtW-1:0] screen_h;
    phase_e          phase;
    logic [7:0]      header;
    logic [7:0]      x_move;
    int              pos_x;
    int              pos_y;
    mouse_report_t   due_reports[$];
    int unsigned     used_bytes;
    int unsigned     errors;

    function new();
      screen_w   = ResetWidth;
      screen_h   = ResetHeight;
      phase      = PhAck;
      header     = '0;
      x_move     = '0;
      used_bytes = 0;
      errors     = 0;
      recentre();
    endfunction

    function void recentre();
      pos_x = (screen_w < CursorSize) ? 0 : (int'(screen_w) - int'(CursorSize)) / 2;
      pos_y = (screen_h < CentreMarginY) ? 0 : (int'(screen_h) - int'(CentreMarginY)) / 2;
    endfunction

    function void set_extent(logic [CfgIdxW-1:0] idx, logic [ExtW-1:0] value);
      if (idx == RegScreenWidth) begin
        screen_w = value;
      end else begin
        screen_h = value;
      end
      recentre();
    endfunction

    function int clamp_move(int pos, int delta, logic [ExtW-1:0] extent);
      int hi;
      int v;
      hi = (extent < CursorSize) ? 0 : int'(extent) - int'(CursorSize);
      v  = pos + delta;
      if (v < 0) begin
        v = 0;
      end
      if (v > hi) begin
        v = hi;
      end
      return v;
    endfunction

    // bytes that the decoder drops leave used_bytes alone
    function void note_byte(logic [7:0] b);
      int            dx;
      int            dy;
      mouse_report_t rpt;
      case (phase)
        PhAck: begin
          if (b == AckByte) begin
            phase = PhHeader;
            used_bytes++;
          end
        end
        PhHeader: begin
          if ((b & SyncMask) == SyncValue) begin
            header = b;
            phase  = PhX;
            used_bytes++;
          end
        end
        PhX: begin
          x_move = b;
          phase  = PhY;
          used_bytes++;
        end
        default: begin
          used_bytes++;
          phase = PhHeader;
          dx = int'(x_move);
          if (header[XSignBit]) begin
            dx -= 256;
          end
          dy = int'(b);
          if (header[YSignBit]) begin
            dy -= 256;
          end
          dy    = -dy;
          pos_x = clamp_move(pos_x, dx, screen_w);
          pos_y = clamp_move(pos_y, dy, screen_h);
          rpt.buttons  = header[2:0];
          rpt.delta_x  = dx[8:0];
          rpt.delta_y  = dy[9:0];
          rpt.cursor_x = pos_x[ExtW-1:0];
          rpt.cursor_y = pos_y[ExtW-1:0];
          due_reports.push_back(rpt);
        end
      endcase
    endfunction

    function void check_field(string name, logic [ExtW-1:0] want, logic [ExtW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(mouse_report_t got);
      mouse_report_t want;
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got %0h", $time, got);
        return;
      end
      want = due_reports.pop_front();
      check_field("buttons", want.buttons, got.buttons);
      check_field("delta_x", want.delta_x, got.delta_x);
      check_field("delta_y", want.delta_y, got.delta_y);
      check_field("cursor_x", want.cursor_x, got.cursor_x);
      check_field("cursor_y", want.cursor_y, got.cursor_y);
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [ExtW-1:0]     cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [7:0]          mouse_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [2:0]          buttons_o;
  logic signed [8:0]   delta_x_o;
  logic signed [9:0]   delta_y_o;
  logic [ExtW-1:0]     cursor_x_o;
  logic [ExtW-1:0]     cursor_y_o;

  bit                  idling_on        = 1'b1;
  bit                  hold_off_request = 1'b0;
  int unsigned         cycle_count      = 0;
  mouse_report_tracker tracker          = new();

  ps2_mouse_packet_decoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mouse_byte_i (mouse_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .buttons_o    (buttons_o),
    .delta_x_o    (delta_x_o),
    .delta_y_o    (delta_y_o),
    .cursor_x_o   (cursor_x_o),
    .cursor_y_o   (cursor_y_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < RunLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("ps2_mouse_packet_decoder_core_test: done, errors");
    $finish;
  end

  // result side: every accepted request is checked against the oldest prediction
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        tracker.check_report('{buttons_o, delta_x_o, delta_y_o, cursor_x_o, cursor_y_o});
      end
    end
  end

  // result side stalls: short bursts, the odd long one, and one long hold-off on demand
  initial begin
    int unsigned run_left;
    int unsigned pick;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_request = 1'b0;
        out_stall_i <= 1'b0;
        run_left = 0;
      end else if (run_left == 0) begin
        pick = $urandom_range(0, 19);
        if (!idling_on || pick < 12) begin
          out_stall_i <= 1'b0;
          run_left = $urandom_range(0, 5);
        end else if (pick < 18) begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(4, 29);
        end
      end else begin
        run_left--;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!idling_on || pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 25);
  endfunction

  // sign and button bits random, sync bits always right
  function automatic logic [7:0] random_header();
    return (8'($urandom) & ~SyncMask) | SyncValue;
  endfunction

  function automatic logic [7:0] random_move();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ExtW-1:0] pick_extent(logic [ExtW-1:0] low);
    if ($urandom_range(0, 1) == 0) begin
      return ExtW'($urandom_range(int'(low), int'(low) + 200));
    end
    return ExtW'($urandom_range(int'(low), int'(ExtentMax)));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mouse_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x_b,
                             input logic [7:0] y_b);
    send_byte(hdr);
    send_byte(x_b);
    send_byte(y_b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ExtW-1:0] value);
    drain();
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_extent(idx, value);
  endtask

  task automatic set_screen(input logic [ExtW-1:0] w, input logic [ExtW-1:0] h);
    write_reg(RegScreenWidth, w);
    write_reg(RegScreenHeight, h);
  endtask

  // mostly whole packets, some stray bytes and some cut-short packets
  task automatic send_random_bytes(input int unsigned target);
    int unsigned goal;
    int unsigned pick;
    goal = tracker.used_bytes + target;
    while (tracker.used_bytes < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_packet(random_header(), random_move(), random_move());
      end else if (pick < 95) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(random_header());
        send_byte(random_move());
      end
    end
  endtask

  initial begin
    int unsigned phase_no;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // dropped before the acknowledge, sync header included
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncValue);
    send_byte(AckByte);
    // headers that fail the sync test
    send_byte(8'h00);
    send_byte(SyncMask);
    send_byte(8'h48);
    send_byte(8'h88);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h3F, 8'hFF, 8'hFF);
    // full negative x and full downward y drive the cursor into both edges
    send_packet(8'h18, 8'h00, 8'h7F);
    send_packet(8'h28, 8'hFF, 8'h00);
    send_packet(8'h0F, 8'hFF, 8'hFF);

    set_screen(WidthMin, HeightMin);
    send_random_bytes(PhaseBytes);
    set_screen(ExtentMax, ExtentMax);
    send_random_bytes(PhaseBytes);

    // receiver holds off while the sender keeps offering, so the queue fills
    set_screen(pick_extent(WidthMin), pick_extent(HeightMin));
    idling_on = 1'b0;
    hold_off_request = 1'b1;
    send_random_bytes(PhaseBytes);
    idling_on = 1'b1;

    for (phase_no = 0; phase_no < 4; phase_no++) begin
      set_screen(pick_extent(WidthMin), pick_extent(HeightMin));
      send_random_bytes(PhaseBytes);
    end

    drain();
    if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
      $display("ps2_mouse_packet_decoder_core_test: done, clean");
    end else begin
      $display("ps2_mouse_packet_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
